[rtl/ascon_hash_xof_sponge_defines.svh]
// Assertion macros used by the sponge RTL file
`ifndef ASCON_HASH_XOF_SPONGE_DEFINES_SVH
`define ASCON_HASH_XOF_SPONGE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge, off during reset
`define AHX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge, off during reset
`define AHX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ahx_pkg.sv]
package ahx_pkg;

   // Output length limits
   localparam int MAX_OUT_BYTES  = 80;
   localparam int HASH_OUT_BYTES = 32;
   localparam int XOF_RST_BYTES  = 32;
   localparam int REM_W          = $clog2(MAX_OUT_BYTES + 1);

   // Permutation
   localparam int NUM_ROUNDS = 12;
   localparam int RND_W      = $clog2(NUM_ROUNDS);

   // Configuration register indexes
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_ADDR_W-1:0] CSR_HASH_MODE     = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_XOF_OUT_BYTES = 1'd1;

   // Padding byte placed after the message
   localparam logic [7:0] PAD_BYTE = 8'h01;

   typedef logic [4:0][63:0] state_type;

   localparam state_type IV_HASH256 = {
      64'h1a5c464906c5976d, 64'h3c7fd4a4d56a4db3, 64'hae65396c6b34b81a,
      64'h4bc3a01e333751d2, 64'h9b1e5494e934d681
   };

   localparam state_type IV_XOF128 = {
      64'he0547524db6f0bde, 64'h0ee0ea53416b58cc, 64'he7508fd780085631,
      64'hcc7ce6c75f1ef969, 64'hda82ce768d9447eb
   };

   // Initial value of the selected mode
   function automatic state_type iv_of(input logic xof_mode);
      return xof_mode ? IV_XOF128 : IV_HASH256;
   endfunction

   // Round constant: high nibble counts down from f, low nibble counts up
   function automatic logic [7:0] round_const(input logic [RND_W-1:0] rnd);
      logic [3:0] lo;
      lo = 4'(rnd);
      return {4'hf - lo, lo};
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
      return (v >> n) | (v << (64 - n));
   endfunction

   // Mask of the n low bytes, n of eight or more gives all ones
   function automatic logic [63:0] low_bytes_mask(input logic [3:0] n);
      logic [63:0] m;
      if (n[3]) begin
         m = '1;
      end else begin
         m = (64'h1 << {n[2:0], 3'b000}) - 64'h1;
      end
      return m;
   endfunction

endpackage

[rtl/ahx_round.sv]
module ahx_round
   import ahx_pkg::*;
(
   input  state_type        x_cur,
   input  logic [RND_W-1:0] rnd_idx,
   output state_type        x_next
);

   // One Ascon round: constant, S-box layer, linear layer
   always_comb begin
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] t0, t1, t2, t3, t4;
      x0 = x_cur[0];
      x1 = x_cur[1];
      x2 = x_cur[2] ^ {56'h0, round_const(rnd_idx)};
      x3 = x_cur[3];
      x4 = x_cur[4];

      // S-box, bitsliced
      x0 = x0 ^ x4;
      x4 = x4 ^ x3;
      x2 = x2 ^ x1;
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      x0 = x0 ^ t1;
      x1 = x1 ^ t2;
      x2 = x2 ^ t3;
      x3 = x3 ^ t4;
      x4 = x4 ^ t0;
      x1 = x1 ^ x0;
      x0 = x0 ^ x4;
      x3 = x3 ^ x2;
      x2 = ~x2;

      // Linear diffusion per word
      x_next[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
      x_next[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
      x_next[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
      x_next[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
      x_next[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
   end

endmodule

[rtl/ascon_hash_xof_sponge.sv]
// Channel   | Direction | Handshake               | Payload
// req_      | in        | req_tvalid / req_tready | tdata: msg_word, byte_count; tlast: is_last
// rsp_      | out       | rsp_tvalid / rsp_tready | tdata: digest_word, valid_bytes; tlast: end
// csr_      | in        | csr_wr_en               | csr_addr, csr_wr_data
//
// One round unit runs twelve times per permutation, one round per cycle.
// A message word that is not last is accepted and then permuted once. A last
// word is permuted once, or twice if it holds eight or more bytes (message
// block, then pad block), and then loads its first digest word, or returns to
// idle with no digest; each further digest word takes one more permutation.
// An output register lets the next item enter while the final digest word
// waits. rsp_tready low while a word is pending holds the sequencer before it
// loads a new digest word. Synchronous reset loads the Hash256 initial value.
`include "ascon_hash_xof_sponge_defines.svh"

module ascon_hash_xof_sponge
   import ahx_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // slave side
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [71:0]           req_tdata,   // [63:0] msg_word, [67:64] byte_count
   input  logic                  req_tlast,   // is_last
   // master side
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [71:0]           rsp_tdata,   // [63:0] digest_word, [67:64] valid_bytes
   output logic                  rsp_tlast,   // end_of_digest
   // configuration
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_PERM, ST_OUT} seq_state_type;
   typedef enum logic [1:0] {PH_ABSORB, PH_PAD, PH_SQUEEZE} phase_type;

   seq_state_type    state_ff, state_in;
   phase_type        phase_ff, phase_in;
   state_type        sponge_ff, sponge_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             mode_ff, mode_in;
   logic [6:0]       xof_ff, xof_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_word_ff, rsp_word_in;
   logic [3:0]       rsp_bytes_ff, rsp_bytes_in;
   logic             rsp_last_ff, rsp_last_in;

   state_type        round_out;
   logic             req_fire;
   logic             out_free;
   logic [63:0]      msg_word;
   logic [3:0]       byte_count;
   logic [REM_W-1:0] rem_init;
   logic [3:0]       take;
   logic             rem_final;

   ahx_round u_round (
      .x_cur   (sponge_ff),
      .rnd_idx (rnd_ff),
      .x_next  (round_out)
   );

   assign msg_word   = req_tdata[63:0];
   assign byte_count = req_tdata[67:64];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_bytes_ff, rsp_word_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Digest length for this message, XOF length saturated
   always_comb begin
      if (!mode_ff) begin
         rem_init = REM_W'(HASH_OUT_BYTES);
      end else if (int'(xof_ff) > MAX_OUT_BYTES) begin
         rem_init = REM_W'(MAX_OUT_BYTES);
      end else begin
         rem_init = REM_W'(xof_ff);
      end
   end

   // Bytes in the next digest word
   assign rem_final = (rem_ff <= REM_W'(8));
   assign take      = rem_final ? 4'(rem_ff) : 4'd8;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      sponge_in    = sponge_ff;
      rnd_in       = rnd_ff;
      rem_in       = rem_ff;
      mode_in      = mode_ff;
      xof_in       = xof_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_word_in  = rsp_word_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // user must write registers only while idle; the block does not enforce it
            if (csr_wr_en) begin
               if (csr_addr == CSR_HASH_MODE) begin
                  mode_in   = csr_wr_data[0];
                  sponge_in = iv_of(csr_wr_data[0]);
               end else if (csr_addr == CSR_XOF_OUT_BYTES) begin
                  xof_in = csr_wr_data[6:0];
               end
            end
            if (req_fire) begin
               rnd_in   = '0;
               state_in = ST_PERM;
               rem_in   = rem_init;
               if (!req_tlast) begin
                  sponge_in[0] = sponge_ff[0] ^ msg_word;
                  phase_in     = PH_ABSORB;
               end else if (byte_count[3]) begin
                  // full last block, padding block follows
                  sponge_in[0] = sponge_ff[0] ^ msg_word;
                  phase_in     = PH_PAD;
               end else begin
                  sponge_in[0] = sponge_ff[0] ^ (msg_word & low_bytes_mask(byte_count))
                               ^ ({56'h0, PAD_BYTE} << {byte_count[2:0], 3'b000});
                  phase_in     = PH_SQUEEZE;
               end
            end
         end
         ST_PERM: begin
            sponge_in = round_out;
            rnd_in    = rnd_ff + RND_W'(1);
            if (rnd_ff == RND_W'(NUM_ROUNDS - 1)) begin
               rnd_in = '0;
               unique case (phase_ff)
                  PH_ABSORB: state_in = ST_IDLE;
                  PH_PAD: begin
                     sponge_in[0] = round_out[0] ^ {56'h0, PAD_BYTE};
                     phase_in     = PH_SQUEEZE;
                  end
                  PH_SQUEEZE: begin
                     if (rem_ff == '0) begin
                        sponge_in = iv_of(mode_ff);
                        state_in  = ST_IDLE;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_OUT: begin
            // load one digest word once the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = sponge_ff[0] & low_bytes_mask(take);
               rsp_bytes_in = take;
               rsp_last_in  = rem_final;
               rem_in       = rem_ff - REM_W'(take);
               if (rem_final) begin
                  sponge_in = iv_of(mode_ff);
                  state_in  = ST_IDLE;
               end else begin
                  state_in = ST_PERM;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_ABSORB;
         sponge_ff    <= IV_HASH256;
         rnd_ff       <= '0;
         rem_ff       <= '0;
         mode_ff      <= 1'b0;
         xof_ff       <= 7'(XOF_RST_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sponge_ff    <= sponge_in;
         rnd_ff       <= rnd_in;
         rem_ff       <= rem_in;
         mode_ff      <= mode_in;
         xof_ff       <= xof_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff  <= rsp_word_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `AHX_ASSERT_NOW(a_rnd_range, clock, reset, 1'b1, rnd_ff < RND_W'(NUM_ROUNDS),
      "round index out of range")
   `AHX_ASSERT_NEXT(a_item_perm, clock, reset, req_fire, state_ff == ST_PERM,
      "item did not start a permutation")
   `AHX_ASSERT_NOW(a_out_rem, clock, reset, state_ff == ST_OUT,
      rem_ff != '0 && phase_ff == PH_SQUEEZE, "squeeze with no bytes left")
   `AHX_ASSERT_NEXT(a_last_idle, clock, reset, state_ff == ST_OUT && out_free && rem_final,
      state_ff == ST_IDLE && rsp_tlast && rsp_tvalid, "final digest word did not end the run")

endmodule

[tb/tb_top.sv]
module tb_top;
   import ahx_pkg::*;

   localparam int  CLK_HIGH          = 6;
   localparam int  CLK_LOW           = 6;
   localparam int  RESET_CYCLES      = 12;
   localparam int  SETTLE_CYCLES     = 48;     // extra idle time after every pending digest word is taken
   localparam int  STALL_LIMIT       = 5000;   // cycles with no item on either channel
   localparam int  HASH_DIGEST_BYTES = 32;
   localparam int  XOF_CAP_BYTES     = 80;
   localparam int  SQUEEZE_BYTES     = 8;
   localparam logic [63:0] PAD_WORD  = 64'h01;
   localparam logic HASH_SEL         = 1'b0;
   localparam logic XOF_SEL          = 1'b1;

   // Round constants, round 0 in the lowest byte
   localparam logic [11:0][7:0] ROUND_K = {
      8'h4b, 8'h5a, 8'h69, 8'h78, 8'h87, 8'h96,
      8'ha5, 8'hb4, 8'hc3, 8'hd2, 8'he1, 8'hf0
   };

   typedef struct {
      logic [63:0] data;
      logic [3:0]  nbytes;
      logic        fin;
   } digest_word_type;

   // DUT ports; the inputs are all known from time zero
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic [71:0]           req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tready  = 1'b0;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr    = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [71:0]           rsp_tdata;
   logic                  rsp_tlast;

   // Predictor state
   logic [63:0]      sponge [5];
   logic             cur_mode;
   logic [6:0]       cur_xof_len;
   digest_word_type  digest_q [$];
   digest_word_type  oldest_word;
   int               err_count = 0;
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;

   ascon_hash_xof_sponge dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [63:0] msg_word, [67:64] byte_count
      .req_tlast   (req_tlast),    // is_last
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [63:0] digest_word, [67:64] valid_bytes
      .rsp_tlast   (rsp_tlast),    // end_of_digest
      .csr_wr_en   (csr_wr_en),
      .csr_addr    (csr_addr),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #CLK_HIGH clock = 1'b1;
      #CLK_LOW  clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
      logic [127:0] d;
      d = {v, v} >> n;
      return d[63:0];
   endfunction

   function automatic logic [63:0] byte_mask(input int n);
      if (n >= 8) return '1;
      return (64'h1 << (8 * n)) - 64'h1;
   endfunction

   // Initial value of the current mode
   function automatic void load_start_value();
      if (cur_mode == XOF_SEL) begin
         sponge[0] = 64'hda82ce768d9447eb;
         sponge[1] = 64'hcc7ce6c75f1ef969;
         sponge[2] = 64'he7508fd780085631;
         sponge[3] = 64'h0ee0ea53416b58cc;
         sponge[4] = 64'he0547524db6f0bde;
      end else begin
         sponge[0] = 64'h9b1e5494e934d681;
         sponge[1] = 64'h4bc3a01e333751d2;
         sponge[2] = 64'hae65396c6b34b81a;
         sponge[3] = 64'h3c7fd4a4d56a4db3;
         sponge[4] = 64'h1a5c464906c5976d;
      end
   endfunction

   // Twelve rounds: constant, S-box, linear layer
   function automatic void permute_sponge();
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] t0, t1, t2, t3, t4;
      x0 = sponge[0]; x1 = sponge[1]; x2 = sponge[2]; x3 = sponge[3]; x4 = sponge[4];
      for (int r = 0; r < 12; r++) begin
         x2 ^= {56'h0, ROUND_K[r]};
         x0 ^= x4; x4 ^= x3; x2 ^= x1;
         t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
         x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
         x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
         x0 ^= ror64(x0, 19) ^ ror64(x0, 28);
         x1 ^= ror64(x1, 61) ^ ror64(x1, 39);
         x2 ^= ror64(x2, 1)  ^ ror64(x2, 6);
         x3 ^= ror64(x3, 10) ^ ror64(x3, 17);
         x4 ^= ror64(x4, 7)  ^ ror64(x4, 41);
      end
      sponge[0] = x0; sponge[1] = x1; sponge[2] = x2; sponge[3] = x3; sponge[4] = x4;
   endfunction

   // Absorb one accepted item; a last word queues the digest words it causes
   function automatic void absorb_and_squeeze(input logic [63:0] word,
                                              input logic [3:0] cnt,
                                              input logic last);
      int left;
      int take;
      digest_word_type d;
      if (!last) begin
         // byte count of a non-last word does not matter
         sponge[0] ^= word;
         permute_sponge();
         return;
      end
      if (cnt >= 8) begin
         // full block, then a block holding only the pad byte
         sponge[0] ^= word;
         permute_sponge();
         sponge[0] ^= PAD_WORD;
      end else begin
         sponge[0] ^= (word & byte_mask(cnt)) ^ (PAD_WORD << (8 * cnt));
      end
      if (cur_mode == XOF_SEL)
         left = (cur_xof_len > XOF_CAP_BYTES) ? XOF_CAP_BYTES : int'(cur_xof_len);
      else
         left = HASH_DIGEST_BYTES;
      permute_sponge();
      while (left > 0) begin
         take     = (left > SQUEEZE_BYTES) ? SQUEEZE_BYTES : left;
         d.data   = sponge[0] & byte_mask(take);
         d.nbytes = 4'(take);
         d.fin    = (left <= SQUEEZE_BYTES);
         digest_q.push_back(d);
         left -= take;
         if (left > 0) permute_sponge();
      end
      load_start_value();
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Hold one item until accepted, with random gaps before it
   task automatic send_item(input logic [63:0] word, input logic [3:0] cnt,
                            input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'h0, cnt, word};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      absorb_and_squeeze(word, cnt, last);
   endtask

   // Stop sending, wait for every pending digest word, then let the block settle
   task automatic drain_and_settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (digest_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_HASH_MODE) begin
         cur_mode = val[0];
         load_start_value();
      end else if (idx == CSR_XOF_OUT_BYTES) begin
         cur_xof_len = val;
      end
      @(posedge clock);
   endtask

   task automatic set_config(input logic mode, input logic [6:0] len);
      drain_and_settle();
      write_csr(CSR_XOF_OUT_BYTES, len);
      write_csr(CSR_HASH_MODE, {6'h0, mode});
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch: %s got %h want %h", what, got, want);
      err_count++;
   endtask

   // Compare each accepted digest word with the oldest pending one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digest_q.size() == 0) begin
            report_mismatch("digest word with none pending", rsp_tdata[63:0], '0);
         end else begin
            oldest_word = digest_q.pop_front();
            if (rsp_tdata[63:0] !== oldest_word.data)
               report_mismatch("digest_word", rsp_tdata[63:0], oldest_word.data);
            if (rsp_tdata[71:64] !== {4'h0, oldest_word.nbytes})
               report_mismatch("valid_bytes", 64'(rsp_tdata[71:64]),
                               64'(oldest_word.nbytes));
            if (rsp_tlast !== oldest_word.fin)
               report_mismatch("end_of_digest", 64'(rsp_tlast), 64'(oldest_word.fin));
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watchdog on cycles where no item moves
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // Hash256 after reset: empty message, full last word, counts above eight
   task automatic test_hash_directed();
      send_item(64'h0, 4'd0, 1'b1);
      send_item('1, 4'd8, 1'b1);
      send_item(64'h0, 4'd8, 1'b0);
      send_item(rand64(), 4'd15, 1'b0);
      send_item(rand64(), 4'd3, 1'b1);
      send_item(rand64(), 4'd9, 1'b1);
      send_item(rand64(), 4'd15, 1'b1);
      send_item(rand64(), 4'd7, 1'b1);
   endtask

   // XOF lengths: one byte, the cap, above the cap, zero, odd length
   task automatic test_xof_lengths();
      set_config(XOF_SEL, 7'd1);
      send_item(rand64(), 4'd5, 1'b1);
      set_config(XOF_SEL, 7'd80);
      send_item(rand64(), 4'd8, 1'b1);
      set_config(XOF_SEL, 7'd127);
      send_item('1, 4'd0, 1'b1);
      set_config(XOF_SEL, 7'd0);
      send_item(rand64(), 4'd8, 1'b1);
      send_item(rand64(), 4'd2, 1'b1);
      set_config(XOF_SEL, 7'd13);
      send_item(rand64(), 4'd0, 1'b0);
      send_item(rand64(), 4'd6, 1'b1);
   endtask

   // Mode write in the middle of a message drops what was absorbed
   task automatic test_mode_switch_midmessage();
      send_item(rand64(), 4'd8, 1'b0);
      send_item(rand64(), 4'd1, 1'b0);
      drain_and_settle();
      write_csr(CSR_HASH_MODE, {6'h0, HASH_SEL});
      send_item(rand64(), 4'd4, 1'b1);
      send_item(rand64(), 4'd8, 1'b0);
      drain_and_settle();
      write_csr(CSR_HASH_MODE, {6'h0, XOF_SEL});
      write_csr(CSR_XOF_OUT_BYTES, 7'd24);
      send_item(rand64(), 4'd8, 1'b1);
   endtask

   function automatic logic [6:0] pick_xof_len();
      case ($urandom_range(4))
         0:       return 7'd0;
         1:       return 7'($urandom_range(1, 8));
         2:       return 7'($urandom_range(9, 79));
         3:       return 7'd80;
         default: return 7'($urandom_range(81, 127));
      endcase
   endfunction

   // Random messages under one idling pattern, with occasional new settings
   task automatic test_random_traffic(input int n_items, input int s_pct, input int r_pct);
      int sent;
      int body;
      logic [3:0] last_cnt;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(3) == 0)
            set_config(1'($urandom_range(1)), pick_xof_len());
         body = ($urandom_range(4) == 0) ? $urandom_range(5, 9) : $urandom_range(0, 3);
         for (int i = 0; i < body; i++)
            send_item(rand64(), 4'($urandom_range(15)), 1'b0);
         sent += body;
         if ($urandom_range(9) == 0) begin
            // broken message: abandoned by a mode write
            drain_and_settle();
            write_csr(CSR_HASH_MODE, {6'h0, 1'($urandom_range(1))});
         end else begin
            last_cnt = ($urandom_range(9) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
            send_item(rand64(), last_cnt, 1'b1);
            sent++;
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      cur_mode    = HASH_SEL;
      cur_xof_len = 7'd32;
      load_start_value();
      send_idle_pct = 31;
      recv_idle_pct = 86;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_hash_directed();
      test_xof_lengths();
      test_mode_switch_midmessage();
      test_random_traffic(115, 31, 86);
      test_random_traffic(115, 86, 31);
      test_random_traffic(115, 0, 0);

      drain_and_settle();
      if (err_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
